// ----- src/hlg_pkg.sv -----
`default_nettype none
package hlg_pkg;

    localparam int COORD_W    = 32;
    localparam int TRIG_W     = 16;
    localparam int TRIG_FRAC  = 14;
    localparam int SPACE_W    = 31;
    localparam int OFFS_W     = 40;
    localparam int PROD_W     = COORD_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NUM_W      = 52;
    localparam int QUO_W      = NUM_W + 1;
    localparam int MUL_CNT_W  = $clog2(TRIG_W);
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int MAX_PTS    = 4;
    localparam int PTS_CNT_W  = $clog2(MAX_PTS + 1);
    localparam int PTS_IDX_W  = $clog2(MAX_PTS);
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 31;
    localparam int S_DATA_W   = 2 * COORD_W;
    localparam int M_DATA_W   = 4 * COORD_W;

    localparam logic [KIND_W-1:0] KIND_ADD_POINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR_COS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd2;

    localparam logic signed [TRIG_W-1:0] DIR_COS_RESET = 16'sd11585;
    localparam logic signed [TRIG_W-1:0] DIR_SIN_RESET = 16'sd11585;
    localparam logic [SPACE_W-1:0]       SPACING_RESET = 31'd65536;

endpackage
`default_nettype wire

// ----- src/hlg_mul.sv -----
`default_nettype none
module hlg_mul (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [hlg_pkg::TRIG_W-1:0]     mplier,
    input  wire logic signed [hlg_pkg::COORD_W-1:0]    mcand,
    output logic                                       done,
    output logic signed [hlg_pkg::PROD_W-1:0]          product
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [hlg_pkg::MUL_CNT_W-1:0]         cnt_reg;
    logic [hlg_pkg::TRIG_W-1:0]            mplier_reg;
    logic signed [hlg_pkg::PROD_W-1:0]     mcand_reg;
    logic signed [hlg_pkg::PROD_W-1:0]     acc_reg;
    logic                                  last_step;

    assign last_step = (cnt_reg == hlg_pkg::MUL_CNT_W'(hlg_pkg::TRIG_W - 1));
    assign done      = done_reg;
    assign product   = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                mplier_reg <= mplier;
                mcand_reg  <= {{(hlg_pkg::PROD_W - hlg_pkg::COORD_W){mcand[hlg_pkg::COORD_W-1]}},
                               mcand};
                acc_reg    <= '0;
            end else if (busy_reg) begin
                if (mplier_reg[0]) begin
                    if (last_step) begin
                        acc_reg <= acc_reg - mcand_reg;
                    end else begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                end
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/hlg_div.sv -----
`default_nettype none
module hlg_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [hlg_pkg::NUM_W-1:0]      num,
    input  wire logic signed [hlg_pkg::TRIG_W-1:0]     den,
    output logic                                       done,
    output logic signed [hlg_pkg::QUO_W-1:0]           quotient
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic                                  neg_reg;
    logic [hlg_pkg::DIV_CNT_W-1:0]         cnt_reg;
    logic [hlg_pkg::NUM_W-1:0]             dvd_reg;
    logic [hlg_pkg::TRIG_W-1:0]            rem_reg;
    logic [hlg_pkg::TRIG_W-1:0]            den_reg;
    logic [hlg_pkg::NUM_W-1:0]             num_mag;
    logic [hlg_pkg::TRIG_W-1:0]            den_mag;
    logic [hlg_pkg::TRIG_W:0]              trial;
    logic [hlg_pkg::TRIG_W:0]              trial_sub;
    logic                                  trial_ge;
    logic [hlg_pkg::QUO_W-1:0]             q_mag;

    always_comb begin
        num_mag   = num[hlg_pkg::NUM_W-1] ? (-num) : num;
        den_mag   = den[hlg_pkg::TRIG_W-1] ? (-den) : den;
        trial     = {rem_reg, dvd_reg[hlg_pkg::NUM_W-1]};
        trial_ge  = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
        q_mag     = {1'b0, dvd_reg};
        quotient  = neg_reg ? (-q_mag) : q_mag;
    end

    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= den_mag;
                neg_reg  <= num[hlg_pkg::NUM_W-1] ^ den[hlg_pkg::TRIG_W-1];
                dvd_reg  <= num_mag + {{(hlg_pkg::NUM_W - hlg_pkg::TRIG_W){1'b0}},
                                       (den_mag >> 1)};
            end else if (busy_reg) begin
                rem_reg <= trial_ge ? trial_sub[hlg_pkg::TRIG_W-1:0]
                                    : trial[hlg_pkg::TRIG_W-1:0];
                dvd_reg <= {dvd_reg[hlg_pkg::NUM_W-2:0], trial_ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == hlg_pkg::DIV_CNT_W'(hlg_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/hatch_line_generator_core.sv -----
`default_nettype none
// Hatch line generator. Input beats on the s_ channel carry a kind in s_tuser: add a
// contour point (s_tdata), start a sweep, step to the next hatch line, or clear the
// contour. Only a next-line beat yields a result beat on the m_ channel: the clipped
// segment in m_tdata, has_segment in m_tuser and sweep_done in m_tlast.
// Add-point and clear beats are handled in the idle state. A start beat runs four
// bit-serial products of the direction and the box edges, then four corners. A
// next-line beat runs the same four products, then a division for each edge whose
// divisor is nonzero, and two more products per clip point when three or four points
// survive; the bit-serial divider makes one quotient bit a cycle over 52 bits.
// An idle or finished sweep answers a next-line beat with sweep_done, skipping the products.
// One item is worked on at a time; s_tready is high whenever no item is in work.
// The result sits in an output register, so a new beat is taken while the receiver
// stalls; a second result waits until the first is taken.
// Reset clears the contour, stops the sweep and loads the default direction and
// spacing. Registers are written through cfg_wr_en, cfg_index and cfg_wr_data.
module hatch_line_generator_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hlg_pkg::S_DATA_W-1:0]      s_tdata,   // point_x, point_y
    input  wire logic [hlg_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [hlg_pkg::M_DATA_W-1:0]           m_tdata,   // x_start, y_start, x_end, y_end
    output logic [0:0]                             m_tuser,   // has_segment
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [hlg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hlg_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int CW = hlg_pkg::COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_CORNER, ST_EDGE, ST_DIV_WAIT,
        ST_EXT_GO, ST_EXT_WAIT, ST_EXT_END, ST_FINISH, ST_OUT
    } state_t;

    localparam logic signed [hlg_pkg::QUO_W-1:0] Q_ONE = 1;
    localparam logic signed [hlg_pkg::SUM_W-1:0] PROJ_ROUND =
        {{(hlg_pkg::SUM_W - hlg_pkg::TRIG_FRAC){1'b0}}, 1'b1, {(hlg_pkg::TRIG_FRAC - 1){1'b0}}};

    state_t                                   state_reg;
    logic signed [hlg_pkg::TRIG_W-1:0]        dir_cos_reg, dir_sin_reg;
    logic [hlg_pkg::SPACE_W-1:0]              spacing_reg;
    logic signed [CW-1:0]                     xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic                                     box_has_reg, sweep_active_reg;
    logic signed [hlg_pkg::OFFS_W-1:0]        offset_now_reg, offset_max_reg;
    logic                                     phase_line_reg, half_reg;
    logic [hlg_pkg::PTS_IDX_W-1:0]            idx_reg;
    logic signed [hlg_pkg::PROD_W-1:0]        sxmin_reg, sxmax_reg, cymin_reg, cymax_reg;
    logic signed [hlg_pkg::PROD_W-1:0]        part_reg;
    logic signed [CW-1:0]                     kx_reg [hlg_pkg::MAX_PTS];
    logic signed [CW-1:0]                     ky_reg [hlg_pkg::MAX_PTS];
    logic [hlg_pkg::PTS_CNT_W-1:0]            kept_cnt_reg;
    logic signed [hlg_pkg::SUM_W-1:0]         tlo_reg, thi_reg;
    logic signed [CW-1:0]                     lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;
    logic                                     res_seg_reg, res_done_reg;
    logic                                     m_tvalid_reg, m_tlast_reg;
    logic [0:0]                               m_tuser_reg;
    logic [hlg_pkg::M_DATA_W-1:0]             m_tdata_reg;

    logic signed [CW-1:0]                     in_x, in_y;
    logic                                     mul_start, mul_done;
    logic signed [hlg_pkg::TRIG_W-1:0]        mul_a;
    logic signed [CW-1:0]                     mul_b;
    logic signed [hlg_pkg::PROD_W-1:0]        mul_p;
    logic                                     div_start, div_done;
    logic signed [hlg_pkg::QUO_W-1:0]         div_q;

    logic                                     edge_vert;
    logic signed [hlg_pkg::TRIG_W-1:0]        edge_den;
    logic signed [hlg_pkg::PROD_W-1:0]        edge_prod;
    logic signed [hlg_pkg::NUM_W-1:0]         edge_prod_ext, edge_cs, edge_num;
    logic signed [CW-1:0]                     edge_fix, edge_lo, edge_hi, edge_clamp;
    logic signed [hlg_pkg::QUO_W-1:0]         edge_lo_ext, edge_hi_ext;
    logic                                     edge_in_range, edge_dup, edge_ins;
    logic signed [CW-1:0]                     raw_x, raw_y;
    logic signed [CW:0]                       dx [hlg_pkg::MAX_PTS];
    logic signed [CW:0]                       dy [hlg_pkg::MAX_PTS];
    logic [hlg_pkg::PTS_CNT_W-1:0]            cnt_after;

    logic signed [hlg_pkg::PROD_W-1:0]        cor_px, cor_py;
    logic signed [hlg_pkg::SUM_W-1:0]         cor_sum, cor_shift;
    logic signed [hlg_pkg::OFFS_W-1:0]        cor_proj;
    logic signed [hlg_pkg::SUM_W-1:0]         ext_t;
    logic                                     ext_lo_upd, ext_hi_upd;

    assign in_x     = s_tdata[CW-1:0];
    assign in_y     = s_tdata[2*CW-1:CW];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    hlg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mplier  (mul_a),
        .mcand   (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    hlg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (edge_num),
        .den      (edge_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        mul_start = (state_reg == ST_MUL_GO) || (state_reg == ST_EXT_GO);
        mul_a     = dir_sin_reg;
        mul_b     = xmin_reg;
        if (state_reg == ST_EXT_GO) begin
            mul_a = half_reg ? dir_sin_reg : dir_cos_reg;
            mul_b = half_reg ? ky_reg[idx_reg] : kx_reg[idx_reg];
        end else begin
            unique case (idx_reg)
                2'd0: begin mul_a = dir_sin_reg; mul_b = xmin_reg; end
                2'd1: begin mul_a = dir_sin_reg; mul_b = xmax_reg; end
                2'd2: begin mul_a = dir_cos_reg; mul_b = ymin_reg; end
                default: begin mul_a = dir_cos_reg; mul_b = ymax_reg; end
            endcase
        end
    end

    always_comb begin
        edge_vert = !idx_reg[1];
        edge_den  = edge_vert ? dir_cos_reg : dir_sin_reg;
        unique case (idx_reg)
            2'd0: begin edge_prod = sxmin_reg; edge_fix = xmin_reg; end
            2'd1: begin edge_prod = sxmax_reg; edge_fix = xmax_reg; end
            2'd2: begin edge_prod = cymin_reg; edge_fix = ymin_reg; end
            default: begin edge_prod = cymax_reg; edge_fix = ymax_reg; end
        endcase
        edge_prod_ext = {{(hlg_pkg::NUM_W - hlg_pkg::PROD_W){edge_prod[hlg_pkg::PROD_W-1]}},
                         edge_prod};
        edge_cs  = {offset_now_reg[hlg_pkg::NUM_W-hlg_pkg::TRIG_FRAC-1:0],
                    {hlg_pkg::TRIG_FRAC{1'b0}}};
        edge_num = edge_vert ? (edge_cs + edge_prod_ext) : (edge_prod_ext - edge_cs);
        div_start = (state_reg == ST_EDGE) && (edge_den != '0);

        edge_lo = edge_vert ? ymin_reg : xmin_reg;
        edge_hi = edge_vert ? ymax_reg : xmax_reg;
        edge_lo_ext = {{(hlg_pkg::QUO_W - CW){edge_lo[CW-1]}}, edge_lo};
        edge_hi_ext = {{(hlg_pkg::QUO_W - CW){edge_hi[CW-1]}}, edge_hi};
        edge_in_range = (div_q >= edge_lo_ext - Q_ONE) && (div_q <= edge_hi_ext + Q_ONE);
        if (div_q < edge_lo_ext) begin
            edge_clamp = edge_lo;
        end else if (div_q > edge_hi_ext) begin
            edge_clamp = edge_hi;
        end else begin
            edge_clamp = div_q[CW-1:0];
        end
        raw_x = edge_vert ? edge_fix : edge_clamp;
        raw_y = edge_vert ? edge_clamp : edge_fix;

        edge_dup = 1'b0;
        for (int j = 0; j < hlg_pkg::MAX_PTS; j++) begin
            dx[j] = {raw_x[CW-1], raw_x} - {kx_reg[j][CW-1], kx_reg[j]};
            dy[j] = {raw_y[CW-1], raw_y} - {ky_reg[j][CW-1], ky_reg[j]};
            if ((hlg_pkg::PTS_CNT_W'(j) < kept_cnt_reg)
                && (dx[j] == '0 || dx[j] == (CW+1)'(1) || dx[j] == '1)
                && (dy[j] == '0 || dy[j] == (CW+1)'(1) || dy[j] == '1)
                && !(dx[j] != '0 && dy[j] != '0)) begin
                edge_dup = 1'b1;
            end
        end
        edge_ins  = edge_in_range && !edge_dup;
        cnt_after = kept_cnt_reg + {{(hlg_pkg::PTS_CNT_W - 1){1'b0}}, edge_ins};
    end

    always_comb begin
        cor_px    = (idx_reg == 2'd0 || idx_reg == 2'd3) ? sxmin_reg : sxmax_reg;
        cor_py    = idx_reg[1] ? cymax_reg : cymin_reg;
        cor_sum   = {cor_py[hlg_pkg::PROD_W-1], cor_py} - {cor_px[hlg_pkg::PROD_W-1], cor_px}
                    + PROJ_ROUND;
        cor_shift = cor_sum >>> hlg_pkg::TRIG_FRAC;
        cor_proj  = cor_shift[hlg_pkg::OFFS_W-1:0];

        ext_t      = {part_reg[hlg_pkg::PROD_W-1], part_reg} + {mul_p[hlg_pkg::PROD_W-1], mul_p};
        ext_lo_upd = (idx_reg == '0) || (ext_t < tlo_reg);
        ext_hi_upd = (idx_reg == '0) || (ext_t >= thi_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            dir_cos_reg      <= hlg_pkg::DIR_COS_RESET;
            dir_sin_reg      <= hlg_pkg::DIR_SIN_RESET;
            spacing_reg      <= hlg_pkg::SPACING_RESET;
            box_has_reg      <= 1'b0;
            sweep_active_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hlg_pkg::CFG_DIR_COS: dir_cos_reg <= cfg_wr_data[hlg_pkg::TRIG_W-1:0];
                    hlg_pkg::CFG_DIR_SIN: dir_sin_reg <= cfg_wr_data[hlg_pkg::TRIG_W-1:0];
                    hlg_pkg::CFG_SPACING: spacing_reg <= cfg_wr_data;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        unique case (s_tuser)
                            hlg_pkg::KIND_ADD_POINT: begin
                                box_has_reg <= 1'b1;
                                if (!box_has_reg) begin
                                    xmin_reg <= in_x;
                                    xmax_reg <= in_x;
                                    ymin_reg <= in_y;
                                    ymax_reg <= in_y;
                                end else begin
                                    if (in_x < xmin_reg) xmin_reg <= in_x;
                                    if (in_x > xmax_reg) xmax_reg <= in_x;
                                    if (in_y < ymin_reg) ymin_reg <= in_y;
                                    if (in_y > ymax_reg) ymax_reg <= in_y;
                                end
                            end
                            hlg_pkg::KIND_CLEAR: begin
                                box_has_reg      <= 1'b0;
                                sweep_active_reg <= 1'b0;
                            end
                            hlg_pkg::KIND_START: begin
                                if (!box_has_reg || spacing_reg == '0) begin
                                    sweep_active_reg <= 1'b0;
                                end else begin
                                    phase_line_reg <= 1'b0;
                                    idx_reg        <= '0;
                                    state_reg      <= ST_MUL_GO;
                                end
                            end
                            default: begin
                                if (!sweep_active_reg || offset_now_reg > offset_max_reg) begin
                                    sweep_active_reg <= 1'b0;
                                    res_done_reg     <= 1'b1;
                                    res_seg_reg      <= 1'b0;
                                    state_reg        <= ST_OUT;
                                end else begin
                                    phase_line_reg <= 1'b1;
                                    idx_reg        <= '0;
                                    kept_cnt_reg   <= '0;
                                    state_reg      <= ST_MUL_GO;
                                end
                            end
                        endcase
                    end
                end
                ST_MUL_GO: begin
                    state_reg <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (mul_done) begin
                        unique case (idx_reg)
                            2'd0: sxmin_reg <= mul_p;
                            2'd1: sxmax_reg <= mul_p;
                            2'd2: cymin_reg <= mul_p;
                            default: cymax_reg <= mul_p;
                        endcase
                        if (idx_reg == 2'd3) begin
                            idx_reg   <= '0;
                            state_reg <= phase_line_reg ? ST_EDGE : ST_CORNER;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_MUL_GO;
                        end
                    end
                end
                ST_CORNER: begin
                    if (idx_reg == '0 || cor_proj < offset_now_reg) offset_now_reg <= cor_proj;
                    if (idx_reg == '0 || cor_proj > offset_max_reg) offset_max_reg <= cor_proj;
                    if (idx_reg == 2'd3) begin
                        sweep_active_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EDGE: begin
                    if (edge_den != '0) begin
                        state_reg <= ST_DIV_WAIT;
                    end else if (idx_reg == 2'd3) begin
                        idx_reg   <= '0;
                        half_reg  <= 1'b0;
                        state_reg <= (kept_cnt_reg > 3'd2) ? ST_EXT_GO : ST_FINISH;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (edge_ins) begin
                            kx_reg[kept_cnt_reg[hlg_pkg::PTS_IDX_W-1:0]] <= raw_x;
                            ky_reg[kept_cnt_reg[hlg_pkg::PTS_IDX_W-1:0]] <= raw_y;
                        end
                        kept_cnt_reg <= cnt_after;
                        if (idx_reg == 2'd3) begin
                            idx_reg   <= '0;
                            half_reg  <= 1'b0;
                            state_reg <= (cnt_after > 3'd2) ? ST_EXT_GO : ST_FINISH;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_EDGE;
                        end
                    end
                end
                ST_EXT_GO: begin
                    state_reg <= ST_EXT_WAIT;
                end
                ST_EXT_WAIT: begin
                    if (mul_done) begin
                        if (!half_reg) begin
                            part_reg  <= mul_p;
                            half_reg  <= 1'b1;
                            state_reg <= ST_EXT_GO;
                        end else begin
                            half_reg <= 1'b0;
                            if (ext_lo_upd) begin
                                tlo_reg  <= ext_t;
                                lo_x_reg <= kx_reg[idx_reg];
                                lo_y_reg <= ky_reg[idx_reg];
                            end
                            if (ext_hi_upd) begin
                                thi_reg  <= ext_t;
                                hi_x_reg <= kx_reg[idx_reg];
                                hi_y_reg <= ky_reg[idx_reg];
                            end
                            if ({1'b0, idx_reg} == kept_cnt_reg - 3'd1) begin
                                state_reg <= ST_EXT_END;
                            end else begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= ST_EXT_GO;
                            end
                        end
                    end
                end
                ST_EXT_END: begin
                    kx_reg[0]    <= lo_x_reg;
                    ky_reg[0]    <= lo_y_reg;
                    kx_reg[1]    <= hi_x_reg;
                    ky_reg[1]    <= hi_y_reg;
                    kept_cnt_reg <= 3'd2;
                    state_reg    <= ST_FINISH;
                end
                ST_FINISH: begin
                    res_seg_reg    <= (kept_cnt_reg == 3'd2);
                    res_done_reg   <= 1'b0;
                    offset_now_reg <= offset_now_reg
                                      + {{(hlg_pkg::OFFS_W - hlg_pkg::SPACE_W){1'b0}}, spacing_reg};
                    state_reg      <= ST_OUT;
                end
                default: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_seg_reg ? {ky_reg[1], kx_reg[1], ky_reg[0], kx_reg[0]}
                                                    : '0;
                        m_tuser_reg  <= res_seg_reg;
                        m_tlast_reg  <= res_done_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- bench/hatch_line_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module hatch_line_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [hlg_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic [hlg_pkg::KIND_W-1:0]        s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [hlg_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire logic [0:0]                        m_tuser,
    input  wire logic                              m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [hlg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hlg_pkg::CFG_W-1:0]         cfg_wr_data,
    output int                                     fails,
    output int                                     pending
);
    import hlg_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               has_segment;
        logic               sweep_done;
    } segment_t;

    segment_t segment_queue[$];

    longint cos_q, sin_q, spacing;
    longint xmin, xmax, ymin, ymax, offs, offs_max;
    bit     has_points, sweeping;

    function automatic longint project_corner(longint x, longint y);
        longint v;
        v = -sin_q * x + cos_q * y;
        return (v + (longint'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint unsigned a, b, q;
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        q = (a + b / 2) / b;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic segment_t clip_hatch_line(longint c);
        segment_t r;
        longint rx[4], ry[4], px[4], py[4];
        longint cs, v, dx, dy, t, tlo, thi, ax, ay, bx, by;
        int n, m, lo, hi;
        bit dup;
        r = '0;
        n = 0;
        m = 0;
        cs = c * (longint'(1) <<< TRIG_FRAC);
        if (cos_q != 0) begin
            for (int i = 0; i < 2; i++) begin
                rx[n] = i ? xmax : xmin;
                v = round_div(cs + sin_q * rx[n], cos_q);
                if (v >= ymin - 1 && v <= ymax + 1) begin
                    ry[n] = clamp(v, ymin, ymax);
                    n++;
                end
            end
        end
        if (sin_q != 0) begin
            for (int i = 0; i < 2; i++) begin
                ry[n] = i ? ymax : ymin;
                v = round_div(cos_q * ry[n] - cs, sin_q);
                if (v >= xmin - 1 && v <= xmax + 1) begin
                    rx[n] = clamp(v, xmin, xmax);
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            dup = 0;
            for (int j = 0; j < m; j++) begin
                dx = rx[i] - px[j];
                dy = ry[i] - py[j];
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx <= 1 && dy <= 1 && !(dx == 1 && dy == 1)) dup = 1;
            end
            if (!dup) begin
                px[m] = rx[i];
                py[m] = ry[i];
                m++;
            end
        end
        if (m > 2) begin
            lo = 0;
            hi = 0;
            tlo = 0;
            thi = 0;
            for (int i = 0; i < m; i++) begin
                t = cos_q * px[i] + sin_q * py[i];
                if (i == 0 || t < tlo) begin
                    tlo = t;
                    lo = i;
                end
                if (i == 0 || t >= thi) begin
                    thi = t;
                    hi = i;
                end
            end
            ax = px[lo];
            ay = py[lo];
            bx = px[hi];
            by = py[hi];
            px[0] = ax;
            py[0] = ay;
            px[1] = bx;
            py[1] = by;
            m = 2;
        end
        if (m == 2) begin
            r.x_start = px[0][COORD_W-1:0];
            r.y_start = py[0][COORD_W-1:0];
            r.x_end = px[1][COORD_W-1:0];
            r.y_end = py[1][COORD_W-1:0];
            r.has_segment = 1;
        end
        return r;
    endfunction

    task automatic apply_beat(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
        longint x, y, v, lo, hi;
        segment_t r;
        x = longint'(signed'(data[COORD_W-1:0]));
        y = longint'(signed'(data[2*COORD_W-1:COORD_W]));
        case (kind)
            KIND_ADD_POINT: begin
                if (!has_points) begin
                    xmin = x; xmax = x; ymin = y; ymax = y;
                    has_points = 1;
                end else begin
                    if (x < xmin) xmin = x;
                    if (x > xmax) xmax = x;
                    if (y < ymin) ymin = y;
                    if (y > ymax) ymax = y;
                end
            end
            KIND_CLEAR: begin
                xmin = 0; xmax = 0; ymin = 0; ymax = 0;
                has_points = 0;
                sweeping = 0;
            end
            KIND_START: begin
                if (!has_points || spacing == 0) begin
                    sweeping = 0;
                end else begin
                    lo = project_corner(xmin, ymin);
                    hi = lo;
                    v = project_corner(xmax, ymin);
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                    v = project_corner(xmax, ymax);
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                    v = project_corner(xmin, ymax);
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                    offs = lo;
                    offs_max = hi;
                    sweeping = 1;
                end
            end
            default: begin
                if (!sweeping || offs > offs_max) begin
                    sweeping = 0;
                    r = '0;
                    r.sweep_done = 1;
                end else begin
                    r = clip_hatch_line(offs);
                    offs = offs + spacing;
                end
                segment_queue = {segment_queue, r};
            end
        endcase
    endtask

    always @(posedge aclk) begin
        segment_t e;
        segment_t a;
        if (!aresetn) begin
            cos_q = DIR_COS_RESET;
            sin_q = DIR_SIN_RESET;
            spacing = SPACING_RESET;
            xmin = 0; xmax = 0; ymin = 0; ymax = 0;
            offs = 0; offs_max = 0;
            has_points = 0;
            sweeping = 0;
            segment_queue.delete();
            fails = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DIR_COS: cos_q = longint'(signed'(cfg_wr_data[TRIG_W-1:0]));
                    CFG_DIR_SIN: sin_q = longint'(signed'(cfg_wr_data[TRIG_W-1:0]));
                    CFG_SPACING: spacing = longint'(cfg_wr_data[SPACE_W-1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) apply_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                a.x_start = m_tdata[COORD_W-1:0];
                a.y_start = m_tdata[2*COORD_W-1:COORD_W];
                a.x_end = m_tdata[3*COORD_W-1:2*COORD_W];
                a.y_end = m_tdata[4*COORD_W-1:3*COORD_W];
                a.has_segment = m_tuser[0];
                a.sweep_done = m_tlast;
                if (segment_queue.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $realtime, a);
                    fails++;
                end else begin
                    e = segment_queue.pop_front();
                    if (a !== e) begin
                        $display("%0t: mismatch expected xs=%h ys=%h xe=%h ye=%h seg=%b done=%b",
                                 $realtime, e.x_start, e.y_start, e.x_end, e.y_end,
                                 e.has_segment, e.sweep_done);
                        $display("%0t:            actual xs=%h ys=%h xe=%h ye=%h seg=%b done=%b",
                                 $realtime, a.x_start, a.y_start, a.x_end, a.y_end,
                                 a.has_segment, a.sweep_done);
                        fails++;
                    end
                end
            end
        end
        pending = segment_queue.size();
    end

endmodule
`default_nettype wire

// ----- bench/hatch_line_generator_core_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module hatch_line_generator_core_test;
    import hlg_pkg::*;

    logic                   aclk = 0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wr_data;
    int                     fails;
    int                     pending;
    int                     items_sent;
    bit                     stall_done;

    hatch_line_generator_core dut (.*);

    hatch_line_checker u_checker (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int len;
        m_tready <= 0;
        stall_done = 0;
        forever begin
            if (!stall_done && items_sent > 300 && pending > 0) begin
                m_tready <= 0;
                repeat (3000) @(posedge aclk);
                stall_done = 1;
            end else if ($urandom_range(0, 2) != 0) begin
                m_tready <= 1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 0;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
                                                   : $urandom_range(1, 4);
                repeat (len) @(posedge aclk);
            end
        end
    end

    task automatic send_beat(logic [KIND_W-1:0] kind, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y);
        int gap;
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        gap = ($urandom_range(0, 2) == 0) ? 0 :
              (($urandom_range(0, 24) == 0) ? $urandom_range(30, 400) : $urandom_range(1, 5));
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        repeat (2) @(posedge aclk);
        while (pending != 0 || !s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic write_direction(int c, int s);
        write_reg(CFG_DIR_COS, {15'($urandom), 16'(c)});
        write_reg(CFG_DIR_SIN, {15'($urandom), 16'(s)});
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int scale_bits);
        if (scale_bits >= 32) return $urandom;
        return COORD_W'(int'($urandom_range(0, (1 << scale_bits) - 1)) - (1 << (scale_bits - 1)));
    endfunction

    initial begin
        int scale_bits, npts, nnext, pick;
        int dc, ds;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        s_tuser <= KIND_ADD_POINT;
        cfg_wr_en <= 0;
        cfg_index <= CFG_DIR_COS;
        cfg_wr_data <= '0;
        items_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_beat(KIND_NEXT, 0, 0);
        send_beat(KIND_START, 0, 0);
        send_beat(KIND_NEXT, 0, 0);
        send_beat(KIND_ADD_POINT, 32'h0001_0000, 32'h0002_0000);
        send_beat(KIND_ADD_POINT, 32'hFFFC_0000, 32'hFFFF_0000);
        send_beat(KIND_START, 0, 0);
        repeat (4) send_beat(KIND_NEXT, 0, 0);
        send_beat(KIND_ADD_POINT, 32'h0008_0000, 32'h0008_0000);
        repeat (3) send_beat(KIND_NEXT, 0, 0);
        send_beat(KIND_CLEAR, 0, 0);
        send_beat(KIND_NEXT, 0, 0);
        send_beat(KIND_ADD_POINT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(KIND_ADD_POINT, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();
        write_reg(CFG_SPACING, 31'h7FFF_FFFF);
        send_beat(KIND_START, 0, 0);
        repeat (3) send_beat(KIND_NEXT, 0, 0);
        wait_drained();
        write_reg(CFG_SPACING, '0);
        send_beat(KIND_START, 0, 0);
        send_beat(KIND_NEXT, 0, 0);
        wait_drained();

        while (items_sent < 1000) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin dc = 16384; ds = 0; end
                1: begin dc = 0; ds = 16384; end
                2: begin dc = -16384; ds = 0; end
                3: begin dc = 0; ds = -16384; end
                4: begin dc = -11585; ds = 11585; end
                5: begin dc = 11585; ds = -11585; end
                6: begin dc = 0; ds = 0; end
                default: begin
                    dc = $urandom_range(0, 32768) - 16384;
                    ds = $urandom_range(0, 32768) - 16384;
                end
            endcase
            wait_idle();
            write_direction(dc, ds);
            scale_bits = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(4, 26);
            case ($urandom_range(0, 11))
                0: write_reg(CFG_SPACING, '0);
                1: write_reg(CFG_SPACING, 31'h7FFF_FFFF);
                2: write_reg(CFG_SPACING, 31'(1 + $urandom_range(0, 3)));
                3: write_reg(CFG_SPACING, 31'($urandom));
                default: write_reg(CFG_SPACING,
                                   31'(1 + $urandom_range(0,
                                       (1 << (scale_bits > 30 ? 30 : scale_bits)) >> 2)));
            endcase

            send_beat(KIND_CLEAR, 0, 0);
            npts = $urandom_range(1, 5);
            repeat (npts) send_beat(KIND_ADD_POINT, rand_coord(scale_bits), rand_coord(scale_bits));
            if ($urandom_range(0, 9) == 0) send_beat(KIND_CLEAR, 0, 0);
            send_beat(KIND_START, 0, 0);
            nnext = (scale_bits >= 28 || $urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                                    : $urandom_range(8, 24);
            repeat (nnext) begin
                case ($urandom_range(0, 19))
                    0: send_beat(KIND_ADD_POINT, rand_coord(scale_bits), rand_coord(scale_bits));
                    1: send_beat(KIND_START, 0, 0);
                    2: send_beat(KIND_CLEAR, 0, 0);
                    default: send_beat(KIND_NEXT, 0, 0);
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                s_tvalid <= 0;
                repeat (2) @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
        end

        s_tvalid <= 0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/hlg_pkg.sv
src/hlg_mul.sv
src/hlg_div.sv
src/hatch_line_generator_core.sv
bench/hatch_line_checker.sv
bench/hatch_line_generator_core_test.sv
